### rtl/core/mscd_pkg.sv
// types and constants shared by the scan change detector modules
`timescale 1ns / 1ps
`default_nettype none
package mscd_pkg;

	localparam int ROW_W  = 3;
	localparam int REG_W  = 4;
	localparam int BYTE_W = 8;
	localparam int PIN_W  = 9;
	localparam int AROW_W = 2;
	localparam int BIT_W  = 3;

	localparam logic REQ_SCAN    = 1'b0;
	localparam logic REQ_SERVICE = 1'b1;

	localparam logic [BYTE_W-1:0] LEVEL_RESET  = 8'hff;
	localparam logic [BYTE_W-1:0] CHANGE_RESET = 8'h00;

	typedef struct packed {
		logic              kind;
		logic [ROW_W-1:0]  row;
		logic [REG_W-1:0]  reg_idx;
		logic [BYTE_W-1:0] data;
		logic [AROW_W-1:0] arow;
	} cmd_t;

endpackage
`default_nettype wire

### rtl/core/mscd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mscd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/mscd_front.sv
// front end: accepts words, tracks the scan row and classifies into commands
`timescale 1ns / 1ps
`default_nettype none
module mscd_front #(
	parameter int ROWS         = 4,
	parameter int REGS_PER_ROW = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         req_type,
	input  wire logic [mscd_pkg::REG_W-1:0]   register_index,
	input  wire logic [mscd_pkg::BYTE_W-1:0]  captured_byte,
	input  wire logic                         row_done,
	input  wire logic [mscd_pkg::AROW_W-1:0]  service_row,
	input  wire logic                         q_full,
	output logic                              q_push,
	output mscd_pkg::cmd_t                    q_cmd
);

	localparam int RW = $clog2(ROWS);

	logic [RW-1:0]              row_q;
	logic [mscd_pkg::ROW_W-1:0] row_ext;
	logic                       accept;
	logic                       reg_ok;
	logic                       row_ok;

	assign full    = q_full;
	assign accept  = push && !q_full;
	assign row_ext = mscd_pkg::ROW_W'(row_q);
	assign reg_ok  = 32'(register_index) < REGS_PER_ROW;
	assign row_ok  = 32'(service_row) < ROWS;

	always_comb begin
		q_cmd.kind    = req_type;
		q_cmd.reg_idx = register_index;
		q_cmd.data    = captured_byte;
		q_cmd.arow    = row_ext[mscd_pkg::AROW_W-1:0];
		if (req_type == mscd_pkg::REQ_SCAN) begin
			q_cmd.row = row_ext;
			q_push    = accept && reg_ok;
		end else begin
			q_cmd.row = mscd_pkg::ROW_W'(service_row);
			q_push    = accept && reg_ok && row_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (accept && req_type == mscd_pkg::REQ_SCAN && row_done) begin
			if (32'(row_q) == ROWS - 1) begin
				row_q <= '0;
			end else begin
				row_q <= row_q + RW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/mscd_queue.sv
// two entry command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module mscd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire mscd_pkg::cmd_t wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output mscd_pkg::cmd_t      rd_data,
	output logic                empty
);

	mscd_pkg::cmd_t mem_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= !wptr_q;
			end
			if (do_rd) begin
				rptr_q <= !rptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/mscd_back.sv
// back end: level/change memories, read-modify-write and event emission
`timescale 1ns / 1ps
`default_nettype none
module mscd_back #(
	parameter int ROWS         = 4,
	parameter int REGS_PER_ROW = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mscd_pkg::cmd_t               q_cmd,
	input  wire logic                         q_empty,
	output logic                              q_pop,
	input  wire logic                         pop,
	output logic                              empty,
	output logic [mscd_pkg::PIN_W-1:0]        pin_number,
	output logic                              pin_level,
	output logic                              last_event,
	output logic [mscd_pkg::AROW_W-1:0]       active_row
);

	localparam int DEPTH = ROWS * REGS_PER_ROW;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                  st_q;
	mscd_pkg::cmd_t              cmd_q;
	logic [AW-1:0]               addr_q;
	logic [AW-1:0]               rd_addr;
	logic [DEPTH-1:0]            vld_q;
	logic [mscd_pkg::BYTE_W-1:0] lvl_rd;
	logic [mscd_pkg::BYTE_W-1:0] chg_rd;
	logic [mscd_pkg::BYTE_W-1:0] lvl_eff;
	logic [mscd_pkg::BYTE_W-1:0] chg_eff;
	logic [mscd_pkg::BYTE_W-1:0] lvl_wd;
	logic [mscd_pkg::BYTE_W-1:0] chg_wd;
	logic                        we;
	logic [mscd_pkg::BYTE_W-1:0] mask_q;
	logic [mscd_pkg::BYTE_W-1:0] lvl_q;
	logic [mscd_pkg::BYTE_W-1:0] mask_nx;
	logic [mscd_pkg::BIT_W-1:0]  bit_idx;
	logic [31:0]                 pin_full;
	logic                        out_vld_q;
	logic                        slot_free;
	logic                        emit;

	assign q_pop   = st_q == ST_IDLE && !q_empty;
	assign rd_addr = AW'(32'(q_cmd.row) * REGS_PER_ROW + 32'(q_cmd.reg_idx));

	mscd_ram #(.WIDTH(mscd_pkg::BYTE_W), .DEPTH(DEPTH)) u_lvl_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_q),
		.wdata (lvl_wd),
		.re    (q_pop),
		.raddr (rd_addr),
		.rdata (lvl_rd)
	);

	mscd_ram #(.WIDTH(mscd_pkg::BYTE_W), .DEPTH(DEPTH)) u_chg_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_q),
		.wdata (chg_wd),
		.re    (q_pop),
		.raddr (rd_addr),
		.rdata (chg_rd)
	);

	// entries never written read as released with no change
	assign lvl_eff = vld_q[addr_q] ? lvl_rd : mscd_pkg::LEVEL_RESET;
	assign chg_eff = vld_q[addr_q] ? chg_rd : mscd_pkg::CHANGE_RESET;
	assign we      = st_q == ST_EXEC;

	always_comb begin
		if (cmd_q.kind == mscd_pkg::REQ_SCAN) begin
			lvl_wd = cmd_q.data;
			chg_wd = chg_eff | (lvl_eff ^ cmd_q.data);
		end else begin
			lvl_wd = lvl_eff;
			chg_wd = mscd_pkg::CHANGE_RESET;
		end
	end

	// lowest set bit of the pending mask
	always_comb begin
		bit_idx = '0;
		for (int i = mscd_pkg::BYTE_W - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				bit_idx = mscd_pkg::BIT_W'(i);
			end
		end
		mask_nx          = mask_q;
		mask_nx[bit_idx] = 1'b0;
	end

	assign pin_full  = 32'(cmd_q.row) * (REGS_PER_ROW * 8) + 32'(cmd_q.reg_idx) * 8
		+ 32'(bit_idx);
	assign slot_free = !out_vld_q || pop;
	assign emit      = st_q == ST_EMIT && slot_free;
	assign empty     = !out_vld_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q  <= q_cmd;
			addr_q <= rd_addr;
		end
		if (st_q == ST_EXEC) begin
			mask_q <= chg_eff;
			lvl_q  <= lvl_eff;
		end else if (emit) begin
			mask_q <= mask_nx;
		end
		if (emit) begin
			pin_number <= mscd_pkg::PIN_W'(pin_full);
			pin_level  <= lvl_q[bit_idx];
			last_event <= mask_nx == '0;
			active_row <= cmd_q.arow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q.kind == mscd_pkg::REQ_SERVICE && chg_eff != '0) begin
						st_q <= ST_EMIT;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit && mask_nx == '0) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/muxed_input_scan_change_detect.sv
// top level of the multiplexed input scan change detector
`timescale 1ns / 1ps
`default_nettype none
// Scan words store one captured byte for the current row and collect sticky
// change bits; a service word takes and clears one entry's change mask and
// yields one toggle word per changed pin, lowest bit first. A scan word passes
// through the back end as a memory read, then a write back; a service word
// then stays in the emit state until its last toggle word is out. The back
// end's read-modify-write of level and change memories sets the pace; a two
// entry command queue lets the front keep taking words meanwhile, and a full
// result register holds the back end until it is popped. No clearing pass
// follows reset: a valid bit per entry makes unwritten entries read as released.
module muxed_input_scan_change_detect #(
	parameter int ROWS         = 4,
	parameter int REGS_PER_ROW = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         req_type,
	input  wire logic [mscd_pkg::REG_W-1:0]   register_index,
	input  wire logic [mscd_pkg::BYTE_W-1:0]  captured_byte,
	input  wire logic                         row_done,
	input  wire logic [mscd_pkg::AROW_W-1:0]  service_row,
	output logic                              empty,
	input  wire logic                         pop,
	output logic [mscd_pkg::PIN_W-1:0]        pin_number,
	output logic                              pin_level,
	output logic                              last_event,
	output logic [mscd_pkg::AROW_W-1:0]       active_row
);

	mscd_pkg::cmd_t wr_cmd;
	mscd_pkg::cmd_t rd_cmd;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;

	mscd_front #(.ROWS(ROWS), .REGS_PER_ROW(REGS_PER_ROW)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.req_type       (req_type),
		.register_index (register_index),
		.captured_byte  (captured_byte),
		.row_done       (row_done),
		.service_row    (service_row),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_cmd          (wr_cmd)
	);

	mscd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (wr_cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (rd_cmd),
		.empty   (q_empty)
	);

	mscd_back #(.ROWS(ROWS), .REGS_PER_ROW(REGS_PER_ROW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_cmd      (rd_cmd),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.pin_number (pin_number),
		.pin_level  (pin_level),
		.last_event (last_event),
		.active_row (active_row)
	);

endmodule
`default_nettype wire

### rtl/core/mscd_checker.sv
// port level checks for the scan change detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mscd_checker #(
	parameter int ROWS = 4
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         empty,
	input wire logic                         pop,
	input wire logic [mscd_pkg::PIN_W-1:0]   pin_number,
	input wire logic                         pin_level,
	input wire logic                         last_event,
	input wire logic [mscd_pkg::AROW_W-1:0]  active_row
);

	logic [mscd_pkg::PIN_W-1:0] prev_pin_q;
	logic                       burst_q;

	// track the previous word of an unfinished service burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q    <= 1'b0;
			prev_pin_q <= '0;
		end else if (pop && !empty) begin
			burst_q    <= !last_event;
			prev_pin_q <= pin_number;
		end
	end

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pin_number) && $stable(pin_level)
			&& $stable(last_event) && $stable(active_row)))
		else $error("waiting result word changed");

	a_burst_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && burst_q) |-> (pin_number[mscd_pkg::PIN_W-1:3] ==
			prev_pin_q[mscd_pkg::PIN_W-1:3] && pin_number[2:0] > prev_pin_q[2:0]))
		else $error("toggle words of one service out of order");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> 32'(active_row) < ROWS)
		else $error("active row out of range");

endmodule

bind muxed_input_scan_change_detect mscd_checker #(.ROWS(ROWS)) u_mscd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.pin_number (pin_number),
	.pin_level  (pin_level),
	.last_event (last_event),
	.active_row (active_row)
);
`default_nettype wire
